>>> rtl/console_line_command_recognizer_core_macros.svh
// ----------------------------------------------------------------------------
// console line command recognizer: assertion macros
// shared concurrent assertion forms, sampled on clock, disabled in reset
// ----------------------------------------------------------------------------
`ifndef CONSOLE_LINE_COMMAND_RECOGNIZER_CORE_MACROS_SVH
`define CONSOLE_LINE_COMMAND_RECOGNIZER_CORE_MACROS_SVH

// condition holds at every edge
`define CLCR_ASSERT_NOW(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define CLCR_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent holds in the cycle after the antecedent
`define CLCR_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/clcr_pkg.sv
// ----------------------------------------------------------------------------
// clcr_pkg
// types, codes and constants shared by the line command recognizer modules
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package clcr_pkg;

   // sizes
   localparam int LINE_CAPACITY_DEFAULT = 1024;
   localparam int CHAR_W                = 8;
   localparam int IDX_W                 = 10;
   localparam int LEN_W                 = 11;
   localparam int MATCH_SPAN            = 7;
   localparam int Q_DEPTH               = 2;

   // special characters
   localparam logic [CHAR_W-1:0] CHAR_NUL = 8'd0;
   localparam logic [CHAR_W-1:0] CHAR_BS  = 8'd8;
   localparam logic [CHAR_W-1:0] CHAR_LF  = 8'd10;
   localparam logic [CHAR_W-1:0] CHAR_DEL = 8'd127;

   // command words, first character in the top byte
   localparam logic [47:0] WORD_SCREAM = "scream";
   localparam logic [39:0] WORD_CLEAR  = "clear";
   localparam logic [15:0] WORD_LS     = "ls";
   localparam logic [15:0] WORD_SL     = "sl";
   localparam logic [31:0] WORD_HELP   = "help";
   localparam logic [31:0] WORD_RUN    = "run ";

   typedef enum logic {
      OP_KEY  = 1'b0,
      OP_READ = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ACT_ECHO  = 2'd0,
      ACT_ERASE = 2'd1,
      ACT_LINE  = 2'd2,
      ACT_READ  = 2'd3
   } act_type;

   typedef enum logic [2:0] {
      CMD_EMPTY   = 3'd0,
      CMD_SCREAM  = 3'd1,
      CMD_CLEAR   = 3'd2,
      CMD_LS      = 3'd3,
      CMD_SL      = 3'd4,
      CMD_HELP    = 3'd5,
      CMD_RUN     = 3'd6,
      CMD_UNKNOWN = 3'd7
   } cmd_type;

   // one classified request on its way to the response side
   typedef struct packed {
      act_type           action;
      logic [CHAR_W-1:0] key;
      cmd_type           command;
      logic [LEN_W-1:0]  length;
      logic              rd_hit;
      logic [CHAR_W-1:0] rd_data;
   } job_type;

endpackage

>>> rtl/clcr_front.sv
// ----------------------------------------------------------------------------
// clcr_front
// accepts requests, keeps the line store and fill count, classifies lines
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "console_line_command_recognizer_core_macros.svh"

module clcr_front #(
   parameter int LINE_CAPACITY = clcr_pkg::LINE_CAPACITY_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_opcode,
   input  logic [clcr_pkg::CHAR_W-1:0]       req_key_char,
   input  logic [clcr_pkg::IDX_W-1:0]        req_read_index,
   output logic                              job_valid,
   input  logic                              job_ready,
   output clcr_pkg::job_type                 job
);
   import clcr_pkg::*;

   localparam int ADDR_W = $clog2(LINE_CAPACITY);
   localparam int FILL_W = $clog2(LINE_CAPACITY + 1);

   logic [CHAR_W-1:0] mem [LINE_CAPACITY];
   logic [CHAR_W-1:0] rdata_ff;
   logic [CHAR_W-1:0] prefix_ff [MATCH_SPAN];

   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [FILL_W-1:0] last_len_ff, last_len_in;
   logic              s1_valid_ff, s1_valid_in;
   job_type           s1_job_ff, s1_job_in;

   logic              fire;
   logic              is_read, is_bs, is_lf, is_chr;
   logic              has_room, not_empty, emits, do_write, rd_hit;
   logic [2:0]        str_len;
   logic              counting;
   cmd_type           cmd;

   // request decode
   assign req_ready = !s1_valid_ff || job_ready;
   assign fire      = req_valid && req_ready;
   assign is_read   = (op_type'(req_opcode) == OP_READ);
   assign is_bs     = !is_read && (req_key_char inside {CHAR_BS, CHAR_DEL});
   assign is_lf     = !is_read && (req_key_char == CHAR_LF);
   assign is_chr    = !is_read && !is_bs && !is_lf;
   assign has_room  = fill_ff < FILL_W'(LINE_CAPACITY);
   assign not_empty = fill_ff != '0;
   assign do_write  = fire && is_chr && has_room;
   assign emits     = is_read || is_lf || (is_bs && not_empty) || (is_chr && has_room);
   assign rd_hit    = (32'(req_read_index) < 32'(last_len_ff)) &&
                      (32'(req_read_index) < LINE_CAPACITY);

   // string length over the match window, stops at a zero byte or the fill
   always_comb begin
      str_len  = '0;
      counting = 1'b1;
      for (int i = 0; i < MATCH_SPAN; i++) begin
         if (counting && (FILL_W'(i) < fill_ff) && (prefix_ff[i] != CHAR_NUL)) begin
            str_len = 3'(i + 1);
         end else begin
            counting = 1'b0;
         end
      end
   end

   // command match on the stored prefix
   always_comb begin
      if (str_len == 3'd0) begin
         cmd = CMD_EMPTY;
      end else if (str_len == 3'd6 && {prefix_ff[0], prefix_ff[1], prefix_ff[2],
                   prefix_ff[3], prefix_ff[4], prefix_ff[5]} == WORD_SCREAM) begin
         cmd = CMD_SCREAM;
      end else if (str_len == 3'd5 && {prefix_ff[0], prefix_ff[1], prefix_ff[2],
                   prefix_ff[3], prefix_ff[4]} == WORD_CLEAR) begin
         cmd = CMD_CLEAR;
      end else if (str_len == 3'd2 && {prefix_ff[0], prefix_ff[1]} == WORD_LS) begin
         cmd = CMD_LS;
      end else if (str_len == 3'd2 && {prefix_ff[0], prefix_ff[1]} == WORD_SL) begin
         cmd = CMD_SL;
      end else if (str_len == 3'd4 && {prefix_ff[0], prefix_ff[1], prefix_ff[2],
                   prefix_ff[3]} == WORD_HELP) begin
         cmd = CMD_HELP;
      end else if (str_len >= 3'd5 && {prefix_ff[0], prefix_ff[1], prefix_ff[2],
                   prefix_ff[3]} == WORD_RUN) begin
         cmd = CMD_RUN;
      end else begin
         cmd = CMD_UNKNOWN;
      end
   end

   // next fill count and last line length
   always_comb begin
      fill_in     = fill_ff;
      last_len_in = last_len_ff;
      if (fire) begin
         if (is_bs && not_empty) begin
            fill_in = fill_ff - 1'b1;
         end else if (is_lf) begin
            fill_in     = '0;
            last_len_in = fill_ff;
         end else if (is_chr && has_room) begin
            fill_in = fill_ff + 1'b1;
         end
      end
   end

   // stage register contents
   always_comb begin
      s1_valid_in = s1_valid_ff && !job_ready;
      s1_job_in   = s1_job_ff;
      if (fire && emits) begin
         s1_valid_in       = 1'b1;
         s1_job_in.key     = req_key_char;
         s1_job_in.command = CMD_EMPTY;
         s1_job_in.length  = '0;
         s1_job_in.rd_hit  = 1'b0;
         s1_job_in.rd_data = '0;
         if (is_read) begin
            s1_job_in.action = ACT_READ;
            s1_job_in.rd_hit = rd_hit;
         end else if (is_bs) begin
            s1_job_in.action = ACT_ERASE;
         end else if (is_lf) begin
            s1_job_in.action  = ACT_LINE;
            s1_job_in.command = cmd;
            s1_job_in.length  = LEN_W'(fill_ff);
         end else begin
            s1_job_in.action = ACT_ECHO;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff     <= '0;
         last_len_ff <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         fill_ff     <= fill_in;
         last_len_ff <= last_len_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      s1_job_ff <= s1_job_in;
   end

   // line store, written and read in request order
   always_ff @(posedge clock) begin
      if (do_write) begin
         mem[fill_ff[ADDR_W-1:0]] <= req_key_char;
      end
      if (fire && is_read) begin
         rdata_ff <= mem[ADDR_W'(req_read_index)];
      end
   end

   // copy of the match window
   always_ff @(posedge clock) begin
      for (int i = 0; i < MATCH_SPAN; i++) begin
         if (do_write && fill_ff == FILL_W'(i)) begin
            prefix_ff[i] <= req_key_char;
         end
      end
   end

   // hand-off to the queue, read data joins the stage
   always_comb begin
      job         = s1_job_ff;
      job.rd_data = rdata_ff;
   end
   assign job_valid = s1_valid_ff;

   `CLCR_ASSERT_NXT(a_line_clears_fill, fire && is_lf, fill_ff == '0 && s1_valid_ff, "line end must clear fill and issue a request")
   `CLCR_ASSERT_NXT(a_stage_holds, s1_valid_ff && !job_ready, s1_valid_ff && $stable(s1_job_ff), "stalled stage lost its request")
   `CLCR_ASSERT_NXT(a_len_only_on_line, !(fire && is_lf), $stable(last_len_ff), "last line length changed without a line end")
   `CLCR_ASSERT_NOW(a_fill_bound, 32'(fill_ff) <= LINE_CAPACITY, "fill count beyond capacity")

endmodule

>>> rtl/clcr_queue.sv
// ----------------------------------------------------------------------------
// clcr_queue
// short request queue between the front and the response side
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "console_line_command_recognizer_core_macros.svh"

module clcr_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  clcr_pkg::job_type in_job,
   output logic              out_valid,
   input  logic              out_ready,
   output clcr_pkg::job_type out_job
);
   import clcr_pkg::*;

   localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
   localparam int CNT_W = $clog2(Q_DEPTH + 1);

   job_type          q_ff [Q_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign in_ready  = count_ff != CNT_W'(Q_DEPTH);
   assign out_valid = count_ff != '0;
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_job   = q_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= in_job;
      end
   end

   `CLCR_ASSERT_NOW(a_count_bound, 32'(count_ff) <= Q_DEPTH, "queue count beyond depth")
   `CLCR_ASSERT_NXT(a_push_grows, push && !pop, count_ff == $past(count_ff) + 1'b1, "push did not grow the queue")
   `CLCR_ASSERT_NXT(a_pop_shrinks, pop && !push, count_ff == $past(count_ff) - 1'b1, "pop did not shrink the queue")

endmodule

>>> rtl/clcr_back.sv
// ----------------------------------------------------------------------------
// clcr_back
// turns queued requests into response fields and holds the output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module clcr_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              job_valid,
   output logic                              job_ready,
   input  clcr_pkg::job_type                 job,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [1:0]                        rsp_action,
   output logic [clcr_pkg::CHAR_W-1:0]       rsp_echo_char,
   output logic [2:0]                        rsp_command,
   output logic [clcr_pkg::LEN_W-1:0]        rsp_line_length,
   output logic [clcr_pkg::CHAR_W-1:0]       rsp_read_byte
);
   import clcr_pkg::*;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        action_ff;
   logic [CHAR_W-1:0] echo_ff, echo_in;
   logic [2:0]        command_ff;
   logic [LEN_W-1:0]  length_ff;
   logic [CHAR_W-1:0] rbyte_ff, rbyte_in;
   logic              take;

   assign job_ready    = !rsp_valid_ff || rsp_ready;
   assign take         = job_valid && job_ready;
   assign rsp_valid_in = take || (rsp_valid_ff && !rsp_ready);

   // echo character and read byte by action
   always_comb begin
      rbyte_in = '0;
      case (job.action)
         ACT_ECHO:  echo_in = job.key;
         ACT_ERASE: echo_in = CHAR_BS;
         ACT_LINE:  echo_in = CHAR_LF;
         ACT_READ: begin
            echo_in  = CHAR_NUL;
            rbyte_in = job.rd_hit ? job.rd_data : '0;
         end
         default:   echo_in = CHAR_NUL;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // output payload
   always_ff @(posedge clock) begin
      if (take) begin
         action_ff  <= job.action;
         echo_ff    <= echo_in;
         command_ff <= job.command;
         length_ff  <= job.length;
         rbyte_ff   <= rbyte_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_action      = action_ff;
   assign rsp_echo_char   = echo_ff;
   assign rsp_command     = command_ff;
   assign rsp_line_length = length_ff;
   assign rsp_read_byte   = rbyte_ff;

endmodule

>>> rtl/console_line_command_recognizer_core.sv
// ----------------------------------------------------------------------------
// console_line_command_recognizer_core
// line buffer with backspace handling, command match and line read-back
// ----------------------------------------------------------------------------
// The block takes one request per clock cycle when the response side is not
// stalled; responses pass the front stage, queue and output register. The line
// store is a single-port memory that is written by typed characters and read
// by read requests in request order; its registered read sets the front
// stage. A two-entry queue and an output register follow, so requests keep
// flowing while a finished response waits. Backspace on an empty line and a
// character on a full line are accepted but give no response.
`timescale 1ns / 1ps

module console_line_command_recognizer_core #(
   parameter int LINE_CAPACITY = clcr_pkg::LINE_CAPACITY_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_opcode,
   input  logic [clcr_pkg::CHAR_W-1:0]       req_key_char,
   input  logic [clcr_pkg::IDX_W-1:0]        req_read_index,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [1:0]                        rsp_action,
   output logic [clcr_pkg::CHAR_W-1:0]       rsp_echo_char,
   output logic [2:0]                        rsp_command,
   output logic [clcr_pkg::LEN_W-1:0]        rsp_line_length,
   output logic [clcr_pkg::CHAR_W-1:0]       rsp_read_byte
);
   import clcr_pkg::*;

   logic    fq_valid, fq_ready;
   job_type fq_job;
   logic    qb_valid, qb_ready;
   job_type qb_job;

   // accept, store and classify
   clcr_front #(
      .LINE_CAPACITY(LINE_CAPACITY)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_opcode     (req_opcode),
      .req_key_char   (req_key_char),
      .req_read_index (req_read_index),
      .job_valid      (fq_valid),
      .job_ready      (fq_ready),
      .job            (fq_job)
   );

   // decoupling queue
   clcr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fq_valid),
      .in_ready  (fq_ready),
      .in_job    (fq_job),
      .out_valid (qb_valid),
      .out_ready (qb_ready),
      .out_job   (qb_job)
   );

   // response formatting and output register
   clcr_back u_back (
      .clock           (clock),
      .reset           (reset),
      .job_valid       (qb_valid),
      .job_ready       (qb_ready),
      .job             (qb_job),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_action      (rsp_action),
      .rsp_echo_char   (rsp_echo_char),
      .rsp_command     (rsp_command),
      .rsp_line_length (rsp_line_length),
      .rsp_read_byte   (rsp_read_byte)
   );

endmodule
